FILE: design/lsdh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsdh_pkg
// Shared constants, controller states and control structs for the LRU stack
// distance histogram.
// ----------------------------------------------------------------------------
package lsdh_pkg;

  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_ADDR_WIDTH  = 32;
  localparam int DEF_COUNT_WIDTH = 32;

  // fixed payload field widths
  localparam int ADDR_FIELD_W  = 32;
  localparam int DIST_FIELD_W  = 6;
  localparam int COUNT_FIELD_W = 32;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SEARCH,
    S_UPDATE
  } lsdh_state_t;

  typedef struct packed {
    logic clear;      // write one zeroed histogram bin
    logic load_addr;  // capture the accepted address
    logic search;     // compare, shift the stack, read the bin
    logic update;     // write back the bin and load the result register
  } lsdh_cmd_t;

  typedef struct packed {
    logic clear_done;  // last bin is being cleared
    logic out_full;    // result register holds an untaken result
  } lsdh_status_t;

endpackage

FILE: design/lsdh_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsdh_in_if
// Access channel: one address per transfer.
// ----------------------------------------------------------------------------
interface lsdh_in_if
  import lsdh_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [ADDR_FIELD_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

FILE: design/lsdh_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsdh_out_if
// Result channel: distance, miss flag and updated bin count per transfer.
// ----------------------------------------------------------------------------
interface lsdh_out_if
  import lsdh_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [DIST_FIELD_W-1:0]  distance;
  logic                     miss;
  logic [COUNT_FIELD_W-1:0] bin_count;

  modport source (output valid, output distance, output miss, output bin_count,
                  input ready);
  modport sink   (input valid, input distance, input miss, input bin_count,
                  output ready);
endinterface

FILE: design/lsdh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsdh_ctrl
// Sequencer: clearing pass after reset, then accept / search / update per
// access, overlapping the next accept with the update.
// ----------------------------------------------------------------------------
module lsdh_ctrl
  import lsdh_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         out_ready,
  input  lsdh_status_t status,
  output logic         in_ready,
  output lsdh_cmd_t    cmd
);

  lsdh_state_t state_r, state_nxt;
  logic        slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign slot_free = !status.out_full || out_ready;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_addr = 1'b1;
          state_nxt     = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        state_nxt  = S_UPDATE;
      end
      S_UPDATE: begin
        // hold until the result register can take the new result
        if (slot_free) begin
          cmd.update = 1'b1;
          in_ready   = 1'b1;
          if (in_valid) begin
            cmd.load_addr = 1'b1;
            state_nxt     = S_SEARCH;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

FILE: design/lsdh_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsdh_stack
// LRU address stack: parallel compare of all entries, hit position encode
// and move-to-top shift. Entries below the fill count are valid.
// ----------------------------------------------------------------------------
module lsdh_stack
  import lsdh_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int ADDR_WIDTH  = DEF_ADDR_WIDTH,
  localparam int POS_W      = $clog2(STACK_DEPTH),
  localparam int FILL_W     = $clog2(STACK_DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [ADDR_FIELD_W-1:0] addr_in,
  input  lsdh_cmd_t               cmd,
  output logic                    hit,
  output logic [POS_W-1:0]        pos
);

  logic [ADDR_WIDTH-1:0]  addr_r;
  logic [ADDR_WIDTH-1:0]  entry_r [STACK_DEPTH];
  logic [FILL_W-1:0]      fill_r;
  logic [STACK_DEPTH-1:0] match;

  always_ff @(posedge clk) begin
    if (cmd.load_addr) begin
      addr_r <= ADDR_WIDTH'(addr_in);
    end
  end

  // valid entries hold distinct addresses, so at most one match
  always_comb begin
    pos = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      match[i] = (FILL_W'(i) < fill_r) && (entry_r[i] == addr_r);
      if (match[i]) begin
        pos = pos | POS_W'(i);
      end
    end
    hit = |match;
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      entry_r[0] <= addr_r;
      for (int i = 1; i < STACK_DEPTH; i++) begin
        if (!hit || (POS_W'(i) <= pos)) begin
          entry_r[i] <= entry_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.search && !hit && (fill_r != FILL_W'(STACK_DEPTH))) begin
      fill_r <= fill_r + 1'b1;
    end
  end

endmodule

FILE: design/lsdh_hist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsdh_hist
// Histogram memory with saturating read-modify-write, clearing sweep and the
// result register.
// ----------------------------------------------------------------------------
module lsdh_hist
  import lsdh_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
  localparam int POS_W      = $clog2(STACK_DEPTH),
  localparam int BIN_W      = $clog2(STACK_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lsdh_cmd_t                cmd,
  input  logic                     hit,
  input  logic [POS_W-1:0]         pos,
  input  logic                     out_ready,
  output lsdh_status_t             status,
  output logic                     out_valid,
  output logic [DIST_FIELD_W-1:0]  out_distance,
  output logic                     out_miss,
  output logic [COUNT_FIELD_W-1:0] out_bin_count
);

  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  logic [COUNT_WIDTH-1:0] mem [STACK_DEPTH + 1];
  logic [COUNT_WIDTH-1:0] rd_data_r;
  logic [COUNT_WIDTH-1:0] inc;
  logic [BIN_W-1:0]       clr_idx_r;
  logic [BIN_W-1:0]       bin;
  logic [BIN_W-1:0]       bin_r;
  logic [POS_W-1:0]       pos_r;
  logic                   hit_r;
  logic                   out_valid_r;
  logic [DIST_FIELD_W-1:0]  distance_r;
  logic                     miss_r;
  logic [COUNT_FIELD_W-1:0] count_r;

  assign bin = hit ? BIN_W'(pos) : BIN_W'(STACK_DEPTH);
  assign inc = (rd_data_r == CountMax) ? CountMax : rd_data_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clear && (clr_idx_r != BIN_W'(STACK_DEPTH))) begin
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  assign status.clear_done = (clr_idx_r == BIN_W'(STACK_DEPTH));
  assign status.out_full   = out_valid_r;

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_idx_r] <= '0;
    end else if (cmd.update) begin
      mem[bin_r] <= inc;
    end
    if (cmd.search) begin
      rd_data_r <= mem[bin];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      bin_r <= bin;
      pos_r <= pos;
      hit_r <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      distance_r <= hit_r ? DIST_FIELD_W'(pos_r) : '0;
      miss_r     <= !hit_r;
      count_r    <= COUNT_FIELD_W'(inc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.update) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_distance  = distance_r;
  assign out_miss      = miss_r;
  assign out_bin_count = count_r;

endmodule

FILE: design/lru_stack_distance_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_stack_distance_histogram
// LRU stack distance measurement with a saturating per-distance histogram.
// ----------------------------------------------------------------------------
// Each address transfer yields one result: its position in an LRU stack of
// STACK_DEPTH distinct addresses (0 for an immediate reuse), a miss flag for
// addresses not in the stack, and the updated count of the outcome's
// histogram bin. The search state compares all stack entries in parallel,
// moves the address to the top and reads the histogram memory; the update
// state that follows writes the incremented bin back and loads the result
// register, while the next address is accepted. A result that is not taken
// holds the update. After reset a clearing pass zeroes the STACK_DEPTH + 1
// histogram bins, one bin per cycle, before the first address is accepted.
// ----------------------------------------------------------------------------
module lru_stack_distance_histogram
  import lsdh_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int ADDR_WIDTH  = DEF_ADDR_WIDTH,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  lsdh_in_if.sink           in_ch,
  lsdh_out_if.source        out_ch
);

  localparam int POS_W = $clog2(STACK_DEPTH);

  lsdh_cmd_t        cmd;
  lsdh_status_t     status;
  logic             hit;
  logic [POS_W-1:0] pos;

  lsdh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .in_ready  (in_ch.ready),
    .cmd       (cmd)
  );

  lsdh_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .addr_in (in_ch.address),
    .cmd     (cmd),
    .hit     (hit),
    .pos     (pos)
  );

  lsdh_hist #(
    .STACK_DEPTH (STACK_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_hist (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .hit           (hit),
    .pos           (pos),
    .out_ready     (out_ch.ready),
    .status        (status),
    .out_valid     (out_ch.valid),
    .out_distance  (out_ch.distance),
    .out_miss      (out_ch.miss),
    .out_bin_count (out_ch.bin_count)
  );

endmodule

FILE: tb/sv/lsdh_access_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsdh_access_checker
// Passive checker for the LRU stack distance histogram: watches both
// channels, keeps its own LRU stack and histogram, predicts the result of
// every accepted address and compares each result transfer in order.
// ----------------------------------------------------------------------------
module lsdh_access_checker
  import lsdh_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [ADDR_FIELD_W-1:0]  in_address,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [DIST_FIELD_W-1:0]  out_distance,
  input  logic                     out_miss,
  input  logic [COUNT_FIELD_W-1:0] out_bin_count,
  output int                       fail_count,
  output int                       results_owed
);

  // shift past the field width wraps to zero, so the mask becomes all ones
  localparam logic [ADDR_FIELD_W-1:0] ADDR_MASK =
    (ADDR_FIELD_W'(1) << DEF_ADDR_WIDTH) - 1'b1;

  localparam int OWED_DEPTH = 16;
  localparam int OWED_W     = $clog2(OWED_DEPTH);

  typedef struct packed {
    logic [DIST_FIELD_W-1:0]  distance;
    logic                     miss;
    logic [COUNT_FIELD_W-1:0] bin_count;
  } access_result_t;

  logic [ADDR_FIELD_W-1:0]    lru_addr  [DEF_STACK_DEPTH];
  logic                       lru_valid [DEF_STACK_DEPTH];
  logic [DEF_COUNT_WIDTH-1:0] dist_hist [DEF_STACK_DEPTH + 1];
  access_result_t             owed_buf  [OWED_DEPTH];
  logic [OWED_W-1:0]          owed_wr_ptr;
  logic [OWED_W-1:0]          owed_rd_ptr;
  int                         owed_count = 0;

  assign results_owed = owed_count;

  // look up the address, move it to the top and bump its histogram bin
  function automatic access_result_t lru_access(input logic [ADDR_FIELD_W-1:0] raw_addr);
    logic [ADDR_FIELD_W-1:0] addr;
    int                      pos;
    access_result_t          res;
    addr = raw_addr & ADDR_MASK;
    pos  = DEF_STACK_DEPTH;
    for (int i = 0; i < DEF_STACK_DEPTH; i++) begin
      if (pos == DEF_STACK_DEPTH && lru_valid[i] && lru_addr[i] == addr) pos = i;
    end
    // a miss shifts the whole stack and drops the bottom entry
    for (int i = (pos < DEF_STACK_DEPTH) ? pos : DEF_STACK_DEPTH - 1; i > 0; i--) begin
      lru_addr[i]  = lru_addr[i-1];
      lru_valid[i] = lru_valid[i-1];
    end
    lru_addr[0]  = addr;
    lru_valid[0] = 1'b1;
    // miss bin sits right after the last distance bin
    if (dist_hist[pos] != '1) dist_hist[pos] = dist_hist[pos] + 1'b1;
    res.miss      = (pos == DEF_STACK_DEPTH);
    res.distance  = res.miss ? '0 : DIST_FIELD_W'(pos);
    res.bin_count = COUNT_FIELD_W'(dist_hist[pos]);
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    access_result_t want;
    if (!rst_n) begin
      fail_count  <= 0;
      owed_wr_ptr = '0;
      owed_rd_ptr = '0;
      owed_count  = 0;
      for (int i = 0; i < DEF_STACK_DEPTH; i++) lru_valid[i] = 1'b0;
      for (int i = 0; i <= DEF_STACK_DEPTH; i++) dist_hist[i] = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_count == 0) begin
          $error("unexpected result transfer: distance %0d miss %0d bin_count %0d",
                 out_distance, out_miss, out_bin_count);
          fail_count <= fail_count + 1;
        end else begin
          want        = owed_buf[owed_rd_ptr];
          owed_rd_ptr = owed_rd_ptr + 1'b1;
          owed_count  = owed_count - 1;
          if (out_distance !== want.distance ||
              out_miss !== want.miss ||
              out_bin_count !== want.bin_count) begin
            fail_count <= fail_count + 1;
          end
          if (out_distance !== want.distance)
            $error("distance: expected %0d, actual %0d", want.distance, out_distance);
          if (out_miss !== want.miss)
            $error("miss: expected %0d, actual %0d", want.miss, out_miss);
          if (out_bin_count !== want.bin_count)
            $error("bin_count: expected %0d, actual %0d", want.bin_count, out_bin_count);
        end
      end
      if (in_valid && in_ready) begin
        if (owed_count == OWED_DEPTH) begin
          $error("too many addresses without a result: %0d", owed_count);
          fail_count <= fail_count + 1;
        end else begin
          owed_buf[owed_wr_ptr] = lru_access(in_address);
          owed_wr_ptr           = owed_wr_ptr + 1'b1;
          owed_count            = owed_count + 1;
        end
      end
    end
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the LRU stack distance histogram: a short directed
// run over boundary addresses and reuse patterns, then random blocks of
// sweeps, working sets, tight reuse and scattered addresses, with random
// gaps on both channels. Checking is done by lsdh_access_checker.
// ----------------------------------------------------------------------------
module testbench;
  import lsdh_pkg::*;

  localparam int RANDOM_ITEMS = 1750;
  localparam int WORK_SET_MAX = 80;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 16;

  typedef enum {
    PAT_SCATTER,
    PAT_WORKING_SET,
    PAT_SWEEP,
    PAT_TIGHT
  } addr_pattern_t;

  logic clk;
  logic rst_n;
  logic idle_on;
  int   fail_count;
  int   results_owed;
  int   stall_cycles;
  int   random_sent;
  logic [ADDR_FIELD_W-1:0] work_set [WORK_SET_MAX];

  lsdh_in_if  in_if();
  lsdh_out_if out_if();

  lru_stack_distance_histogram u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  lsdh_access_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_if.valid),
    .in_ready      (in_if.ready),
    .in_address    (in_if.address),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_distance  (out_if.distance),
    .out_miss      (out_if.miss),
    .out_bin_count (out_if.bin_count),
    .fail_count    (fail_count),
    .results_owed  (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // one address transfer; valid stays high when the next one follows at once
  task automatic send_access(input logic [ADDR_FIELD_W-1:0] addr);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.address <= addr;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic run_block(input addr_pattern_t pat, input int span, input int count);
    logic [ADDR_FIELD_W-1:0] addr;
    for (int i = 0; i < WORK_SET_MAX; i++) work_set[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      case (pat)
        PAT_SCATTER: addr = $urandom;
        PAT_SWEEP:   addr = work_set[n % span];
        default:     addr = work_set[$urandom_range(0, span - 1)];
      endcase
      // a stray address now and then breaks up the reuse pattern
      if (pat == PAT_WORKING_SET && $urandom_range(0, 15) == 0) addr = $urandom;
      send_access(addr);
    end
    random_sent += count;
  endtask

  // result side: random hold-off before each transfer
  initial begin
    int gap;
    out_if.ready = 1'b0;
    forever begin
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("lru_stack_distance_histogram: mismatch");
    $finish;
  end

  initial begin
    addr_pattern_t pat;
    int            span;
    rst_n         = 1'b0;
    idle_on       = 1'b1;
    random_sent   = 0;
    in_if.valid   = 1'b0;
    in_if.address = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: boundary addresses, first touches, immediate and short reuse
    send_access(32'h0000_0000);
    send_access(32'hFFFF_FFFF);
    send_access(32'h0000_0000);
    send_access(32'h0000_0000);
    send_access(32'hFFFF_FFFF);
    send_access(32'h8000_0000);
    send_access(32'h0000_0001);
    send_access(32'hAAAA_AAAA);
    send_access(32'h5555_5555);
    send_access(32'h0000_0000);
    send_access(32'hFFFF_FFFE);
    send_access(32'h7FFF_FFFF);
    send_access(32'h8000_0000);
    send_access(32'hFFFF_FFFF);
    send_access(32'h5555_5555);
    send_access(32'h5555_5555);
    send_access(32'h0000_0001);
    send_access(32'hAAAA_AAAA);
    send_access(32'h1234_5678);
    send_access(32'h7FFF_FFFF);

    // sweeps around the stack depth: deepest hit, eviction on every access, one short of the deepest
    idle_on = 1'b0;
    run_block(PAT_SWEEP, DEF_STACK_DEPTH, 200);
    idle_on = 1'b1;
    run_block(PAT_SWEEP, DEF_STACK_DEPTH + 1, 150);
    run_block(PAT_SWEEP, DEF_STACK_DEPTH - 1, 130);

    while (random_sent < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7))
        0:       begin pat = PAT_SCATTER;     span = 1; end
        1, 2:    begin pat = PAT_TIGHT;       span = $urandom_range(1, 4); end
        3:       begin pat = PAT_SWEEP;       span = $urandom_range(2, WORK_SET_MAX); end
        default: begin pat = PAT_WORKING_SET; span = $urandom_range(1, WORK_SET_MAX); end
      endcase
      run_block(pat, span, $urandom_range(60, 160));
    end
    in_if.valid <= 1'b0;

    while (results_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("lru_stack_distance_histogram: match");
    end else begin
      $display("lru_stack_distance_histogram: mismatch");
    end
    $finish;
  end

endmodule

FILE: lru_stack_distance_histogram.f
design/lsdh_pkg.sv
design/lsdh_in_if.sv
design/lsdh_out_if.sv
design/lsdh_ctrl.sv
design/lsdh_stack.sv
design/lsdh_hist.sv
design/lru_stack_distance_histogram.sv
tb/sv/lsdh_access_checker.sv
tb/sv/testbench.sv
